// ===== hdl/pdts_pkg.sv =====
// Shared types and codes for the pass dependency topological sort block.
// Used by pdts_ctrl, pdts_dp and pass_dependency_topo_sort.
package pdts_pkg;
  // Store depth: pass and resource slots.
  localparam int MAX_PASSES    = 32;
  localparam int MAX_RESOURCES = 64;

  localparam logic [1:0] KIND_TOUCH   = 2'd0;
  localparam logic [1:0] KIND_COMPILE = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  localparam logic CFG_PASS_COUNT     = 1'b0;
  localparam logic CFG_RESOURCE_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] pass_index;
    logic [5:0] resource_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] pass_index_res;
    logic       last;
  } out_item_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic touch;      // record the input touch
    logic clear;      // empty the touch store
    logic build_init; // zero edges and degrees, start at resource 0
    logic build_step; // process one resource column
    logic seed_step;  // test one pass for zero in-degree
    logic pop;        // take the queue head as current pass
    logic visit_step; // visit one successor of current pass
  } dp_cmd_t;

  typedef struct packed {
    logic build_done;
    logic seed_done;
    logic queue_empty;
    logic visit_done;
  } dp_stat_t;
endpackage

// ===== hdl/pass_dependency_topo_sort.sv =====
// Pass dependency ordering by Kahn topological sort.
// Touch and clear items: one result per touch, none per clear; next item once the output is free.
// Compile: accept, edge build over the resources, seeding of each pass, then per pass
// a pop, a visit of every pass and an emit, then a final pop;
// emit waits while the output register holds an unaccepted result.
// Synchronous reset clears the touch store, counts, registers and queue pointers.
module pass_dependency_topo_sort (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pdts_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pdts_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [6:0]           cfg_data
);
  import pdts_pkg::*;
  logic [5:0] pass_count;
  logic [6:0] resource_count;
  logic [6:0] np, nr;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [4:0] cur_pass;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count     <= '0;
      resource_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PASS_COUNT:     pass_count     <= cfg_data[5:0];
        CFG_RESOURCE_COUNT: resource_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign np = (7'(pass_count) > 7'(MAX_PASSES)) ? 7'(MAX_PASSES) : 7'(pass_count);
  assign nr = (resource_count > 7'(MAX_RESOURCES)) ? 7'(MAX_RESOURCES) : resource_count;

  pdts_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .np, .nr, .cmd, .stat, .cur_pass
  );

  pdts_dp u_dp (
    .clk, .rst, .cmd, .stat,
    .t_pass(in_data.pass_index), .t_res(in_data.resource_index),
    .np, .nr, .cur_pass
  );
endmodule

// ===== hdl/pdts_dp.sv =====
// Datapath: touch store, edge builder, in-degree counts and ready queue.
// Depends on pdts_pkg; driven by pdts_ctrl commands.
module pdts_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  pdts_pkg::dp_cmd_t       cmd,
  output pdts_pkg::dp_stat_t      stat,
  input  logic [4:0]              t_pass,
  input  logic [5:0]              t_res,
  input  logic [6:0]              np,
  input  logic [6:0]              nr,
  output logic [4:0]              cur_pass
);
  import pdts_pkg::*;
  localparam int PW = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;
  localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int CW = $clog2(MAX_PASSES + 1);

  logic [MAX_RESOURCES-1:0] touch_map [MAX_PASSES];
  logic [MAX_PASSES-1:0]    edge_map  [MAX_PASSES];
  logic [CW-1:0]            in_degree [MAX_PASSES];
  logic [PW-1:0]            ready_queue [MAX_PASSES];
  logic [CW-1:0]            queue_head, queue_tail;
  logic [6:0]               scan;     // resource, seed or successor counter
  logic [PW-1:0]            cur;

  // Column of touches for the resource under scan, limited to active passes.
  logic [MAX_PASSES-1:0] col;
  logic [MAX_PASSES-1:0] new_pred [MAX_PASSES];
  always_comb begin
    for (int p = 0; p < MAX_PASSES; p++) begin
      col[p] = touch_map[p][scan[RW-1:0]] && (7'(p) < np);
    end
    // Each touching pass links to the next touching pass above it.
    for (int p = 0; p < MAX_PASSES; p++) begin
      new_pred[p] = '0;
    end
    for (int p = 0; p < MAX_PASSES; p++) begin
      logic found;
      found = 1'b0;
      for (int q = p + 1; q < MAX_PASSES; q++) begin
        if (col[p] && col[q] && !found) begin
          new_pred[q][p] = 1'b1;
          found = 1'b1;
        end
      end
    end
  end

  logic [6:0] nr_eff;
  assign nr_eff = (nr > 7'(MAX_RESOURCES)) ? 7'(MAX_RESOURCES) : nr;

  logic visit_hit;
  logic [PW-1:0] scan_p;
  assign scan_p = scan[PW-1:0];
  assign visit_hit = edge_map[cur][scan_p] && (in_degree[scan_p] != '0);

  // Update store, edges, degrees and queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < MAX_PASSES; p++) begin
        touch_map[p] <= '0;
        edge_map[p]  <= '0;
        in_degree[p] <= '0;
      end
      queue_head <= '0;
      queue_tail <= '0;
      scan       <= '0;
      cur        <= '0;
    end else begin
      if (cmd.touch) touch_map[t_pass[PW-1:0]][t_res[RW-1:0]] <= 1'b1;
      if (cmd.clear) begin
        for (int p = 0; p < MAX_PASSES; p++) touch_map[p] <= '0;
      end
      if (cmd.build_init) begin
        for (int p = 0; p < MAX_PASSES; p++) begin
          edge_map[p]  <= '0;
          in_degree[p] <= '0;
        end
        scan       <= '0;
        queue_head <= '0;
        queue_tail <= '0;
      end
      if (cmd.build_step) begin
        for (int q = 0; q < MAX_PASSES; q++) begin
          logic inc;
          inc = 1'b0;
          for (int p = 0; p < MAX_PASSES; p++) begin
            if (new_pred[q][p] && !edge_map[p][q]) begin
              edge_map[p][q] <= 1'b1;
              inc = 1'b1;
            end
          end
          // At most one new predecessor per column.
          if (inc) in_degree[q] <= in_degree[q] + 1'b1;
        end
        scan <= (scan + 7'd1 >= nr_eff) ? 7'd0 : scan + 7'd1;
      end
      if (cmd.seed_step) begin
        if (in_degree[scan_p] == '0) begin
          ready_queue[queue_tail[PW-1:0]] <= scan_p;
          queue_tail <= queue_tail + 1'b1;
        end
        scan <= (scan + 7'd1 >= np) ? 7'd0 : scan + 7'd1;
      end
      if (cmd.pop) begin
        cur        <= ready_queue[queue_head[PW-1:0]];
        queue_head <= queue_head + 1'b1;
        scan       <= '0;
      end
      if (cmd.visit_step) begin
        if (visit_hit) begin
          in_degree[scan_p] <= in_degree[scan_p] - 1'b1;
          if (in_degree[scan_p] == CW'(1)) begin
            ready_queue[queue_tail[PW-1:0]] <= scan_p;
            queue_tail <= queue_tail + 1'b1;
          end
        end
        scan <= scan + 7'd1;
      end
    end
  end

  assign stat.build_done  = (scan + 7'd1 >= nr_eff);
  assign stat.seed_done   = (scan + 7'd1 >= np);
  assign stat.queue_empty = (queue_head == queue_tail);
  assign stat.visit_done  = (scan + 7'd1 >= np);
  assign cur_pass = 5'(cur);

  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    queue_tail <= CW'(MAX_PASSES)) else $error("queue tail overflow");
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    queue_head <= queue_tail) else $error("queue head passed tail");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> queue_head != queue_tail) else $error("pop from empty queue");
endmodule

// ===== hdl/pdts_ctrl.sv =====
// Controller: sequences touch, clear and compile items and drives results.
// Depends on pdts_pkg; commands pdts_dp.
module pdts_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pdts_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pdts_pkg::out_item_t   out_data,
  input  logic [6:0]            np,
  input  logic [6:0]            nr,
  output pdts_pkg::dp_cmd_t     cmd,
  input  pdts_pkg::dp_stat_t    stat,
  input  logic [4:0]            cur_pass
);
  import pdts_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_BUILD, S_SEED, S_POP, S_EMIT, S_VISIT} state_t;
  state_t state;

  logic out_free, accept, bad, out_load;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign bad = (7'(in_data.pass_index) >= np) || (7'(in_data.resource_index) >= nr);

  // Load the output register on a touch result, an empty compile or an order entry.
  assign out_load = (accept && (in_data.kind == KIND_TOUCH ||
                                (in_data.kind == KIND_COMPILE && np == '0))) ||
                    (state == S_EMIT && out_free);

  // Commands from state and current item.
  always_comb begin
    cmd = '0;
    cmd.touch      = accept && in_data.kind == KIND_TOUCH && !bad;
    cmd.clear      = accept && in_data.kind == KIND_CLEAR;
    cmd.build_init = accept && in_data.kind == KIND_COMPILE && np != '0;
    cmd.build_step = state == S_BUILD && nr != '0;
    cmd.seed_step  = state == S_SEED;
    cmd.pop        = state == S_POP && !stat.queue_empty;
    cmd.visit_step = state == S_VISIT;
  end

  // Hold state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      out_data  <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.kind)
              KIND_TOUCH: begin
                out_data <= '{status: bad ? ST_REJECT : ST_OK,
                              pass_index_res: '0, last: 1'b1};
              end
              KIND_COMPILE: begin
                if (np == '0) begin
                  out_data <= '{status: ST_EMPTY, pass_index_res: '0, last: 1'b1};
                end else begin
                  state <= S_BUILD;
                end
              end
              default: ;
            endcase
          end
        end
        S_BUILD: if (nr == '0 || stat.build_done) state <= S_SEED;
        S_SEED:  if (stat.seed_done) state <= S_POP;
        S_POP:   state <= stat.queue_empty ? S_IDLE : S_VISIT;
        S_VISIT: if (stat.visit_done) state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            out_data <= '{status: ST_OK, pass_index_res: cur_pass, last: stat.queue_empty};
            state    <= S_POP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_noaccept: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("accept while busy");
  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_data)) else $error("result changed while stalled");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && stat.queue_empty) |=> state == S_POP)
    else $error("sequence lost");
endmodule
